FILE: rtl/vdbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdbs_pkg - shared types and constants
// Constants, opcodes and the command record passed from decoder to bitmap engine.
// ----------------------------------------------------------------------------
package vdbs_pkg;

  // Bitmap geometry
  localparam int unsigned MAX_DOCS  = 1048576;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned NUM_WORDS = MAX_DOCS >> 6;
  localparam int unsigned WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [31:0] NUM_WORDS_W = 32'(NUM_WORDS);
  localparam int unsigned BIT_IDX_W = $clog2(WORD_BITS);

  // Field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 21;
  localparam int unsigned WIDX_W   = 14;
  localparam int unsigned ID_W     = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LIST_BYTE = 2'd0,
    OP_START     = 2'd1,
    OP_READ      = 2'd2,
    OP_WRITE     = 2'd3
  } op_e;

  typedef enum logic {
    RK_ID   = 1'b0,
    RK_WORD = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  // One command for the bitmap engine. For CMD_SET, data holds the one-hot
  // bit mask; for CMD_WRITE, the new word.
  typedef struct packed {
    cmd_e                   kind;
    logic                   in_range;
    logic [WORD_AW-1:0]     addr;
    logic [WORD_BITS-1:0]   data;
    logic [ID_W-1:0]        id;
    logic                   done;
  } cmd_t;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);

endpackage
`default_nettype wire

FILE: rtl/vdbs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdbs_if - item and result channels
// Valid/ready channels for input items and result transactions.
// ----------------------------------------------------------------------------
interface vdbs_item_if;
  import vdbs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [BYTE_W-1:0]     list_byte;
  logic [COUNT_W-1:0]    doc_count;
  logic [WIDX_W-1:0]     word_index;
  logic [WORD_BITS-1:0]  word_value;

  modport source (output valid, opcode, list_byte, doc_count, word_index, word_value,
                  input ready);
  modport sink   (input valid, opcode, list_byte, doc_count, word_index, word_value,
                  output ready);
endinterface

interface vdbs_result_if;
  import vdbs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  result_kind;
  logic [ID_W-1:0]       document_id;
  logic [WORD_BITS-1:0]  read_word;
  logic                  out_of_range;
  logic                  list_done;

  modport source (output valid, result_kind, document_id, read_word, out_of_range,
                  list_done, input ready);
  modport sink   (input valid, result_kind, document_id, read_word, out_of_range,
                  list_done, output ready);
endinterface
`default_nettype wire

FILE: rtl/vdbs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdbs_front - item decoder
// Takes items, assembles varint deltas into ids and issues bitmap commands.
// ----------------------------------------------------------------------------
module vdbs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  vdbs_item_if.sink          item_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output vdbs_pkg::cmd_t     cmd_o
);
  import vdbs_pkg::*;

  logic [ID_W-1:0]    partial_q, partial_d;
  logic [2:0]         group_q, group_d;
  logic [ID_W-1:0]    prev_q, prev_d;
  logic [COUNT_W-1:0] remain_q, remain_d;

  logic accept;
  assign item_i.ready = !q_full_i;
  assign accept       = item_i.valid && !q_full_i;

  always_comb begin
    logic [ID_W-1:0]  grp;
    logic [ID_W-1:0]  merged;
    logic [ID_W-1:0]  new_id;
    logic [ID_W-1:0]  word_ext;
    logic [ID_W-1:0]  widx_ext;

    partial_d = partial_q;
    group_d   = group_q;
    prev_d    = prev_q;
    remain_d  = remain_q;
    push_o    = 1'b0;
    cmd_o     = '0;

    grp = ID_W'(item_i.list_byte[6:0]);
    case (group_q)
      3'd0:    merged = partial_q | grp;
      3'd1:    merged = partial_q | (grp << 7);
      3'd2:    merged = partial_q | (grp << 14);
      3'd3:    merged = partial_q | (grp << 21);
      3'd4:    merged = partial_q | (grp << 28);
      default: merged = partial_q;   // groups past bit 31 are dropped
    endcase
    new_id   = prev_q + merged;
    word_ext = {6'd0, new_id[ID_W-1:6]};
    widx_ext = ID_W'(item_i.word_index);

    if (accept) begin
      case (op_e'(item_i.opcode))
        OP_START: begin
          remain_d  = item_i.doc_count;
          prev_d    = '0;
          partial_d = '0;
          group_d   = '0;
        end
        OP_READ, OP_WRITE: begin
          push_o         = 1'b1;
          cmd_o.kind     = (op_e'(item_i.opcode) == OP_READ) ? CMD_READ : CMD_WRITE;
          cmd_o.in_range = widx_ext < NUM_WORDS_W;
          cmd_o.addr     = widx_ext[WORD_AW-1:0];
          cmd_o.data     = item_i.word_value;
        end
        OP_LIST_BYTE: begin
          if (remain_q != '0) begin
            if (item_i.list_byte[7]) begin
              partial_d = merged;
              if (group_q < 3'd5) begin
                group_d = group_q + 3'd1;
              end
            end else begin
              partial_d      = '0;
              group_d        = '0;
              prev_d         = new_id;
              remain_d       = remain_q - COUNT_W'(1);
              push_o         = 1'b1;
              cmd_o.kind     = CMD_SET;
              cmd_o.in_range = word_ext < NUM_WORDS_W;
              cmd_o.addr     = word_ext[WORD_AW-1:0];
              cmd_o.data     = WORD_BITS'(1) << new_id[BIT_IDX_W-1:0];
              cmd_o.id       = new_id;
              cmd_o.done     = (remain_q == COUNT_W'(1));
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      group_q   <= '0;
      prev_q    <= '0;
      remain_q  <= '0;
    end else begin
      partial_q <= partial_d;
      group_q   <= group_d;
      prev_q    <= prev_d;
      remain_q  <= remain_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vdbs_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdbs_cmd_fifo - command queue
// Two-entry queue decoupling the decoder from the bitmap engine.
// ----------------------------------------------------------------------------
module vdbs_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire vdbs_pkg::cmd_t  data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output vdbs_pkg::cmd_t       data_o,
  output logic                 empty_o
);
  import vdbs_pkg::*;

  cmd_t               entry_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PW:0]   count_q;

  assign full_o  = (count_q == (FIFO_PW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (FIFO_PW+1)'(1);
        2'b01:   count_q <= count_q - (FIFO_PW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vdbs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdbs_back - bitmap engine
// Read-modify-write of bitmap words with forwarding, plus the result register.
// ----------------------------------------------------------------------------
module vdbs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire vdbs_pkg::cmd_t  cmd_i,
  input  wire logic            cmd_valid_i,
  output logic                 pop_o,
  vdbs_result_if.source        result_o
);
  import vdbs_pkg::*;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  logic                 s1_valid_q;
  cmd_t                 s1_q;

  logic                 lw_valid_q;
  logic [WORD_AW-1:0]   lw_addr_q;
  logic [WORD_BITS-1:0] lw_data_q;

  logic                 out_valid_q;
  logic                 out_kind_q;
  logic [ID_W-1:0]      out_id_q;
  logic [WORD_BITS-1:0] out_word_q;
  logic                 out_oor_q;
  logic                 out_done_q;

  logic                 has_res, out_free, s1_adv, wr_en;
  logic [WORD_BITS-1:0] old_word, new_word;

  assign has_res  = (s1_q.kind != CMD_WRITE);
  assign out_free = !out_valid_q || result_o.ready;
  assign s1_adv   = s1_valid_q && (!has_res || out_free);
  assign pop_o    = cmd_valid_i && (!s1_valid_q || s1_adv);

  // latest write wins over the registered read, which misses a same-edge write
  assign old_word = (lw_valid_q && lw_addr_q == s1_q.addr) ? lw_data_q : rdata_q;
  assign new_word = (s1_q.kind == CMD_SET) ? (old_word | s1_q.data) : s1_q.data;
  assign wr_en    = s1_adv && s1_q.in_range && (s1_q.kind != CMD_READ);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_q.addr] <= new_word;
    end
    if (pop_o) begin
      rdata_q <= mem[cmd_i.addr];
      s1_q    <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lw_addr_q <= s1_q.addr;
      lw_data_q <= new_word;
    end
    if (s1_adv && has_res) begin
      case (s1_q.kind)
        CMD_SET: begin
          out_kind_q <= RK_ID;
          out_id_q   <= s1_q.id;
          out_word_q <= '0;
          out_oor_q  <= !s1_q.in_range;
          out_done_q <= s1_q.done;
        end
        default: begin
          out_kind_q <= RK_WORD;
          out_id_q   <= '0;
          out_word_q <= s1_q.in_range ? old_word : '0;
          out_oor_q  <= 1'b0;
          out_done_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        lw_valid_q <= 1'b1;
      end
      if (s1_adv && has_res) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.result_kind  = out_kind_q;
  assign result_o.document_id  = out_id_q;
  assign result_o.read_word    = out_word_q;
  assign result_o.out_of_range = out_oor_q;
  assign result_o.list_done    = out_done_q;

endmodule
`default_nettype wire

FILE: rtl/varint_delta_bitmap_setter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// varint_delta_bitmap_setter - varint delta list decoder into a doc bitmap
// Decodes variable-byte, delta coded document ids and sets their bitmap bits.
// ----------------------------------------------------------------------------
// Takes one transaction per clock on item_i while the command queue has room,
// and gives at most one result transaction per item on result_o, in item
// order. Opcodes: list byte (7 data bits, low group first, bit 7 = more bytes
// follow), start list (loads the id count, clears the running id), read word
// and write word on the MAX_DOCS/64-word bitmap. An id result passes through
// the command queue, the bitmap read stage and the result register after its
// closing byte is taken. The rate is set by the bitmap memory, which has one
// read and one write port; back-to-back updates of the same word are forwarded
// from the last-write register. The bitmap is not cleared at reset: software
// clears it with word writes before the first list, and reading or updating a
// word never written gives undefined data.
// ----------------------------------------------------------------------------
module varint_delta_bitmap_setter (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  vdbs_item_if.sink      item_i,
  vdbs_result_if.source  result_o
);
  import vdbs_pkg::*;

  // decoder -> queue
  logic q_push, q_full;
  cmd_t q_in;

  // queue -> bitmap engine
  logic q_pop, q_empty;
  cmd_t q_head;

  // Front: varint assembly, delta add, range checks and bit mask build.
  vdbs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (q_in)
  );

  // Short queue lets the decoder keep taking bytes while results stall.
  vdbs_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty)
  );

  // Back: bitmap read-modify-write and the result register.
  vdbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_head),
    .cmd_valid_i (!q_empty),
    .pop_o       (q_pop),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire
